// File: sv/fdl_pkg.sv
// shared types and constants for the feedback delay lowpass echo
package fdl_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    localparam t_cfg_index CFG_DELAY_LENGTH  = 4'd0;
    localparam t_cfg_index CFG_FEEDBACK_GAIN = 4'd1;
    localparam t_cfg_index CFG_WET_MIX       = 4'd2;
    localparam t_cfg_index CFG_LOWPASS_COEFF = 4'd3;

    // unity gain in unsigned q1.15 and the feedback clamp of 0.999 in signed q1.15
    localparam logic [15:0]        UNITY      = 16'd32768;
    localparam logic signed [15:0] FB_LIMIT   = 16'sd32735;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FILT,
        S_SMOOTH,
        S_MIX,
        S_WRITE
    } t_state;

endpackage

// File: sv/fdl_ram.sv
// generic single-port-write, registered-read ram
module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/feedback_delay_lowpass.sv
// feedback echo with a one-pole lowpass in the feedback path: top level
// Each sample passes through the sequencer states in order: accepting it and
// starting the delay memory read, then the read data, the lowpass multiply, the
// filter state update, the three mix and feedback multiplies side by side, and
// the write back to the delay memory, which waits while a held output is
// stalled. The sequencer works on one sample at a time, taking no new one until
// its write back is done; a finished result waits in the output register while
// the next sample is taken. Writing the delay length clears the pointer and
// filter state at once; the delay memory needs no clearing pass, since entries
// not yet written since that write read as zero until the pointer first wraps.
module feedback_delay_lowpass #(
    parameter int MAX_DELAY   = 32768,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_sample,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  fdl_pkg::t_cfg_index     i_cfg_index,
    input  fdl_pkg::t_cfg_word      i_cfg_data
);

    import fdl_pkg::*;

    localparam int W   = SAMPLE_BITS;
    localparam int AW  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LW  = $clog2(MAX_DELAY + 1);
    localparam int SW  = W + 8;
    localparam int DW  = W + 9;
    localparam int GW  = DW + 17;
    localparam int XW  = W + 12;
    localparam int P1W = W + 18;
    localparam int P2W = SW + 17;
    localparam int P3W = SW + 16;
    localparam int MW  = W + 27;

    localparam logic signed [GW-1:0]  G_HALF  = GW'(1) << 14;
    localparam logic signed [MW-1:0]  M_HALF  = MW'(1) << 22;
    localparam logic signed [P3W-1:0] F_HALF  = P3W'(1) << 22;

    t_state r_state, n_state;

    logic [LW-1:0]        r_len;
    logic signed [15:0]   r_fb;
    logic [15:0]          r_wet;
    logic [15:0]          r_coeff;

    logic [AW-1:0]        r_ptr;
    logic                 r_filled;
    logic signed [SW-1:0] r_smooth;

    logic signed [W-1:0]   r_x;
    logic signed [DW-1:0]  r_diff;
    logic signed [GW-1:0]  r_prod_g;
    logic signed [P1W-1:0] r_p1;
    logic signed [P2W-1:0] r_p2;
    logic signed [P3W-1:0] r_p3;

    logic                 r_out_valid;
    logic signed [W-1:0]  r_out_sample;

    logic                 ram_re;
    logic                 ram_we;
    logic [W-1:0]         ram_rdata;
    logic signed [W-1:0]  wb_sample;
    logic signed [W-1:0]  n_out_sample;

    logic                 slot_free;
    logic                 in_take;
    logic                 cfg_take;
    logic                 len_write;
    logic [31:0]          cfg_len32;

    logic signed [W-1:0]   rd_sample;
    logic signed [DW-1:0]  n_diff;
    logic signed [GW-1:0]  g_sum;
    logic signed [XW-1:0]  s_sum;
    logic signed [SW-1:0]  n_smooth;
    logic [16:0]           dry_gain;
    logic signed [MW-1:0]  m_sum;
    logic signed [W+3:0]   m_round;
    logic signed [P3W-1:0] f_sum;
    logic signed [W+1:0]   wb_sum;
    logic [LW-1:0]         ptr_inc;

    fdl_ram #(
        .WIDTH (W),
        .DEPTH (MAX_DELAY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (wb_sample),
        .i_re    (ram_re),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign in_take     = i_in_valid && !o_in_stall;
    assign cfg_take    = i_cfg_valid && o_cfg_ready;
    assign len_write   = cfg_take && (i_cfg_index == CFG_DELAY_LENGTH);
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_sample = r_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ram_re  = 1'b0;
        ram_we  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    ram_re  = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ:   n_state = S_FILT;
            S_FILT:   n_state = S_SMOOTH;
            S_SMOOTH: n_state = S_MIX;
            S_MIX:    n_state = S_WRITE;
            S_WRITE: begin
                if (slot_free) begin
                    ram_we  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath arithmetic
    always_comb begin
        rd_sample = r_filled ? $signed(ram_rdata) : '0;
        n_diff    = $signed({rd_sample, 8'h00}) - $signed({r_smooth[SW-1], r_smooth});

        g_sum = r_prod_g + G_HALF;
        s_sum = XW'(r_smooth) + XW'($signed(g_sum[GW-1:15]));
        if (&s_sum[XW-1:SW-1] || ~|s_sum[XW-1:SW-1]) begin
            n_smooth = s_sum[SW-1:0];
        end else begin
            n_smooth = s_sum[XW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end

        dry_gain = {1'b0, UNITY} - {1'b0, r_wet};

        m_sum   = MW'($signed({r_p1, 8'h00})) + MW'(r_p2) + M_HALF;
        m_round = m_sum[MW-1:23];
        if (&m_round[W+3:W-1] || ~|m_round[W+3:W-1]) begin
            n_out_sample = m_round[W-1:0];
        end else begin
            n_out_sample = m_round[W+3] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end

        f_sum  = r_p3 + F_HALF;
        wb_sum = (W+2)'(r_x) + (W+2)'($signed(f_sum[P3W-1:23]));
        if (&wb_sum[W+1:W-1] || ~|wb_sum[W+1:W-1]) begin
            wb_sample = wb_sum[W-1:0];
        end else begin
            wb_sample = wb_sum[W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end

        ptr_inc = LW'(r_ptr) + LW'(1);

        if (i_cfg_data == '0) begin
            cfg_len32 = 32'd1;
        end else if (32'(i_cfg_data) > 32'(MAX_DELAY)) begin
            cfg_len32 = 32'(MAX_DELAY);
        end else begin
            cfg_len32 = 32'(i_cfg_data);
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x <= i_in_sample;
        end
        if (r_state == S_READ) begin
            r_diff <= n_diff;
        end
        if (r_state == S_FILT) begin
            r_prod_g <= $signed({1'b0, r_coeff}) * r_diff;
        end
        if (r_state == S_MIX) begin
            r_p1 <= $signed({1'b0, dry_gain}) * r_x;
            r_p2 <= $signed({1'b0, r_wet}) * r_smooth;
            r_p3 <= r_fb * r_smooth;
        end
        if (ram_we) begin
            r_out_sample <= n_out_sample;
        end
    end

    // output register, pointer, filter state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_filled    <= 1'b0;
            r_smooth    <= '0;
            r_len       <= LW'(1);
            r_fb        <= '0;
            r_wet       <= '0;
            r_coeff     <= UNITY;
        end else begin
            if (ram_we) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (len_write) begin
                r_ptr    <= '0;
                r_filled <= 1'b0;
                r_smooth <= '0;
            end else begin
                if (r_state == S_SMOOTH) begin
                    r_smooth <= n_smooth;
                end
                if (ram_we) begin
                    if (ptr_inc >= r_len) begin
                        r_ptr    <= '0;
                        r_filled <= 1'b1;
                    end else begin
                        r_ptr <= ptr_inc[AW-1:0];
                    end
                end
            end
            if (cfg_take) begin
                case (i_cfg_index)
                    CFG_DELAY_LENGTH: begin
                        r_len <= cfg_len32[LW-1:0];
                    end
                    CFG_FEEDBACK_GAIN: begin
                        if ($signed(i_cfg_data) > FB_LIMIT) begin
                            r_fb <= FB_LIMIT;
                        end else if ($signed(i_cfg_data) < -FB_LIMIT) begin
                            r_fb <= -FB_LIMIT;
                        end else begin
                            r_fb <= $signed(i_cfg_data);
                        end
                    end
                    CFG_WET_MIX: begin
                        r_wet <= (i_cfg_data > UNITY) ? UNITY : i_cfg_data;
                    end
                    CFG_LOWPASS_COEFF: begin
                        r_coeff <= (i_cfg_data > UNITY) ? UNITY : i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_ptr) < r_len)
        else $error("store pointer beyond delay length");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len != '0)
        else $error("delay length is zero");

    a_take_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_READ)
        else $error("accepted beat did not start a read");

    a_ptr_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_ptr == '0) || (r_ptr == $past(r_ptr) + AW'(1)))
        else $error("pointer did not advance after write back");

    a_len_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_take && i_cfg_index == CFG_DELAY_LENGTH)
        |=> (!r_filled && r_ptr == '0 && r_smooth == '0))
        else $error("delay length write did not clear the line");

    a_out_only_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WRITE)
        else $error("output beat raised outside write back");

endmodule
